// ----- rtl/core/stkb_pkg.sv -----
package stkb_pkg;

   // Pixel and channel geometry (ARGB, 8 bits per channel).
   localparam int PIX_W  = 32;
   localparam int CH_W   = 8;
   localparam int NUM_CH = 3;

   // Radius and window geometry.
   localparam int RAD_W       = 6;
   localparam int MAX_RADIUS  = 63;
   localparam int STORE_DEPTH = 2 * MAX_RADIUS + 1;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = 7;
   localparam int COUNT_MAX   = 127;
   localparam int TAP_W       = 7;
   localparam int WT_W        = 7;
   localparam int POS_W       = 9;

   // Arithmetic widths: weighted sum and divisor (radius+1)^2.
   localparam int SUM_W     = 20;
   localparam int DIVR_W    = 13;
   localparam int DIV_CNT_W = $clog2(SUM_W + 1);

   localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic tap_issue;
      logic div_start;
      logic out_load;
      logic next_centre;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic has_centre;
      logic tap_last;
      logic div_busy;
      logic out_free;
      logic centre_last;
   } sts_type;

endpackage

// ----- rtl/core/stkb_div.sv -----
module stkb_div import stkb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  dividend,
   input  logic [DIVR_W-1:0] divisor,
   output logic [CH_W-1:0]   quotient,
   output logic              busy
);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]     dvd_ff, dvd_in;
   logic [DIVR_W-1:0]    rem_ff, rem_in;
   logic [DIVR_W-1:0]    dvr_ff, dvr_in;
   logic [CH_W-1:0]      quo_ff, quo_in;
   logic [DIVR_W:0]      trial;
   logic [DIVR_W:0]      diff;
   logic                 ge;

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

   // One restoring step per cycle: shift in the next dividend bit and try a subtract.
   always_comb begin
      trial  = {rem_ff, dvd_ff[SUM_W-1]};
      diff   = trial - {1'b0, dvr_ff};
      ge     = (trial >= {1'b0, dvr_ff});
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dvr_in = dvr_ff;
      quo_in = quo_ff;
      if (start) begin
         cnt_in = DIV_CNT_W'(SUM_W);
         dvd_in = dividend;
         rem_in = '0;
         dvr_in = divisor;
         quo_in = '0;
      end else if (busy) begin
         cnt_in = cnt_ff - 1'b1;
         dvd_in = {dvd_ff[SUM_W-2:0], 1'b0};
         rem_in = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
         // The quotient never exceeds one channel, so higher bits are always zero.
         quo_in = {quo_ff[CH_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvr_ff <= dvr_in;
      quo_ff <= quo_in;
   end

endmodule

// ----- rtl/core/stkb_datapath.sv -----
module stkb_datapath import stkb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic [PIX_W-1:0] in_pixel,
   input  logic             in_last,
   input  logic             csr_write,
   input  logic [RAD_W-1:0] csr_radius,
   output logic [PIX_W-1:0] out_pixel,
   output logic             out_last,
   output logic             out_valid,
   input  logic             out_ready
);

   logic [PIX_W-1:0]  store [STORE_DEPTH];

   logic [RAD_W-1:0]  radius_ff, radius_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] wptr_ff, wptr_in;
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [RAD_W-1:0]  r_ff, r_in;
   logic              last_ff, last_in;
   logic [RAD_W-1:0]  k_ff, k_in;
   logic [TAP_W-1:0]  t_ff, t_in;
   logic [DIVR_W-1:0] divisor_ff, divisor_in;
   logic              tap_v_ff, tap_v_in;
   logic [WT_W-1:0]   wt_ff, wt_in;
   logic              ctap_ff, ctap_in;
   logic [PIX_W-1:0]  rd_data_ff;
   logic [SUM_W-1:0]  acc_ff [NUM_CH];
   logic [SUM_W-1:0]  acc_in [NUM_CH];
   logic [CH_W-1:0]   alpha_ff, alpha_in;
   logic [PIX_W-1:0]  out_pix_ff, out_pix_in;
   logic              out_last_ff, out_last_in;
   logic              out_valid_ff, out_valid_in;

   logic [2*WT_W-1:0] rp1;
   logic [POS_W-1:0]  pos;
   logic [CNT_W-1:0]  pclamp;
   logic [CNT_W-1:0]  back;
   logic [ADDR_W:0]   addr_sum;
   logic [ADDR_W-1:0] rd_addr;
   logic [CH_W-1:0]   quo [NUM_CH];
   logic [NUM_CH-1:0] busy;
   logic              acc_clear;

   // Radius register, written from the configuration port.
   always_comb begin
      radius_in = csr_write ? csr_radius : radius_ff;
   end

   // Tap address: line position of the tap, clamped to the line, then back from the newest slot.
   always_comb begin
      pos = POS_W'(n_ff) - POS_W'(k_ff) - POS_W'(r_ff) + POS_W'(t_ff);
      if (pos[POS_W-1]) begin
         pclamp = '0;
      end else if (pos[POS_W-2:0] > {1'b0, n_ff}) begin
         pclamp = n_ff;
      end else begin
         pclamp = pos[CNT_W-1:0];
      end
      back     = n_ff - pclamp;
      addr_sum = {1'b0, slot_ff} + (ADDR_W+1)'(STORE_DEPTH) - {1'b0, back};
      if (addr_sum >= (ADDR_W+1)'(STORE_DEPTH)) begin
         rd_addr = ADDR_W'(addr_sum - (ADDR_W+1)'(STORE_DEPTH));
      end else begin
         rd_addr = addr_sum[ADDR_W-1:0];
      end
   end

   // Line bookkeeping and per-item control registers.
   always_comb begin
      rp1        = (2*WT_W)'(radius_ff) + 1'b1;
      count_in   = count_ff;
      wptr_in    = wptr_ff;
      slot_in    = slot_ff;
      n_in       = n_ff;
      r_in       = r_ff;
      last_in    = last_ff;
      k_in       = k_ff;
      t_in       = t_ff;
      divisor_in = divisor_ff;
      if (cmd.load) begin
         slot_in    = wptr_ff;
         wptr_in    = (wptr_ff == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         n_in       = count_ff;
         r_in       = radius_ff;
         last_in    = in_last;
         t_in       = '0;
         divisor_in = DIVR_W'(rp1 * rp1);
         if (in_last) begin
            count_in = '0;
         end else if (count_ff != CNT_W'(COUNT_MAX)) begin
            count_in = count_ff + 1'b1;
         end
         // Flush starts at the oldest centre still owed; a normal item has one centre.
         if (in_last && (count_ff < {1'b0, radius_ff})) begin
            k_in = count_ff[RAD_W-1:0];
         end else begin
            k_in = radius_ff;
         end
      end else if (cmd.next_centre) begin
         k_in = k_ff - 1'b1;
         t_in = '0;
      end else if (cmd.tap_issue) begin
         t_in = t_ff + 1'b1;
      end
   end

   // Tap pipeline: weight and centre flag line up with the registered read data.
   always_comb begin
      tap_v_in = cmd.tap_issue;
      ctap_in  = (t_ff == TAP_W'(r_ff));
      if (t_ff <= TAP_W'(r_ff)) begin
         wt_in = WT_W'(t_ff) + 1'b1;
      end else begin
         wt_in = WT_W'({r_ff, 1'b0}) + 1'b1 - WT_W'(t_ff);
      end
   end

   // Weighted sums, one per color channel, and the centre alpha.
   always_comb begin
      acc_clear = cmd.load | cmd.next_centre;
      for (int i = 0; i < NUM_CH; i++) begin
         if (acc_clear) begin
            acc_in[i] = '0;
         end else if (tap_v_ff) begin
            acc_in[i] = acc_ff[i]
                      + SUM_W'(rd_data_ff[CH_W*(NUM_CH-1-i) +: CH_W]) * SUM_W'(wt_ff);
         end else begin
            acc_in[i] = acc_ff[i];
         end
      end
      alpha_in = (tap_v_ff && ctap_ff) ? rd_data_ff[PIX_W-1 -: CH_W] : alpha_ff;
   end

   // Output register; it frees up in the same cycle that the item is taken.
   always_comb begin
      out_pix_in   = out_pix_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff & ~out_ready;
      if (cmd.out_load) begin
         out_pix_in   = {alpha_ff, quo[0], quo[1], quo[2]};
         out_last_in  = last_ff && (k_ff == '0);
         out_valid_in = 1'b1;
      end
   end

   // Window store: one write port for arriving pixels, one registered read port for taps.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         store[wptr_ff] <= in_pixel;
      end
      if (cmd.tap_issue) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   // Dividers by (radius+1)^2, one per channel, started together.
   for (genvar g = 0; g < NUM_CH; g++) begin : g_div
      stkb_div u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (cmd.div_start),
         .dividend (acc_ff[g]),
         .divisor  (divisor_ff),
         .quotient (quo[g]),
         .busy     (busy[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= RADIUS_RESET;
         count_ff     <= '0;
         wptr_ff      <= '0;
         tap_v_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         radius_ff    <= radius_in;
         count_ff     <= count_in;
         wptr_ff      <= wptr_in;
         tap_v_ff     <= tap_v_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      n_ff        <= n_in;
      r_ff        <= r_in;
      last_ff     <= last_in;
      k_ff        <= k_in;
      t_ff        <= t_in;
      divisor_ff  <= divisor_in;
      wt_ff       <= wt_in;
      ctap_ff     <= ctap_in;
      alpha_ff    <= alpha_in;
      out_pix_ff  <= out_pix_in;
      out_last_ff <= out_last_in;
      for (int i = 0; i < NUM_CH; i++) begin
         acc_ff[i] <= acc_in[i];
      end
   end

   // Status to the controller.
   always_comb begin
      sts.has_centre  = in_last || ({1'b0, radius_ff} <= count_ff);
      sts.tap_last    = (t_ff == TAP_W'({r_ff, 1'b0}));
      sts.div_busy    = |busy;
      sts.out_free    = ~out_valid_ff | out_ready;
      sts.centre_last = ~last_ff | (k_ff == '0);
   end

   assign out_pixel = out_pix_ff;
   assign out_last  = out_last_ff;
   assign out_valid = out_valid_ff;

endmodule

// ----- rtl/core/stkb_ctrl.sv -----
module stkb_ctrl import stkb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_TAP   = 6'b000010,
      ST_DRAIN = 6'b000100,
      ST_START = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Commands follow directly from the state, the request valid and the datapath status.
   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      cmd.load        = req_ready & req_valid;
      cmd.tap_issue   = (state_ff == ST_TAP);
      cmd.div_start   = (state_ff == ST_START);
      cmd.out_load    = (state_ff == ST_EMIT) & sts.out_free;
      cmd.next_centre = (state_ff == ST_EMIT) & sts.out_free & ~sts.centre_last;
   end

   // Item sequence: taps, drain of the read pipeline, divide, hand off to the output register.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.has_centre) begin
               state_in = ST_TAP;
            end
         end
         ST_TAP: begin
            if (sts.tap_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!sts.div_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               state_in = sts.centre_last ? ST_IDLE : ST_TAP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/stack_blur_line.sv -----
// Channel  Direction  Payload
// req      in         tdata[31:0] pixel_in (ARGB), tlast last_in_line
// rsp      out        tdata[31:0] pixel_out (ARGB), tlast last_out
// csr      in         tdata[5:0] radius, tdata[7:6] unused
//
// Each blurred pixel takes 2*radius+1 taps through the window store's
// read port, a pipeline drain step, a divider start step, the divide step
// (SUM_W (20) bit-serial steps and a check that they are done) and a
// hand-off step, after the item has been accepted.
// An item with no result to give is only accepted and stored in the window.
// An item is accepted only when the previous one has finished; a line end
// produces up to radius+1 results back to back in that way.
// Reset is synchronous and active high; radius resets to 1 and the line restarts.
// A stalled rsp side holds the block in its hand-off step; one finished pixel
// waits in the output register while the next one is computed.
module stack_blur_line import stkb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // Fields from bit 0: pixel_in[31:0].
   input  logic [PIX_W-1:0] req_tdata,
   input  logic             req_tlast,
   input  logic             req_tvalid,
   output logic             req_tready,
   // Fields from bit 0: pixel_out[31:0].
   output logic [PIX_W-1:0] rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // Fields from bit 0: radius[5:0], then two unused bits.
   input  logic [7:0]       csr_tdata,
   input  logic             csr_tvalid,
   output logic             csr_tready
);

   cmd_type cmd;
   sts_type sts;

   // The radius register takes a write in any cycle.
   assign csr_tready = 1'b1;

   stkb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stkb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_pixel   (req_tdata),
      .in_last    (req_tlast),
      .csr_write  (csr_tvalid),
      .csr_radius (csr_tdata[RAD_W-1:0]),
      .out_pixel  (rsp_tdata),
      .out_last   (rsp_tlast),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready)
   );

endmodule
